@@ hw/rtl/ele_pkg.sv @@
// ----------------------------------------------------------------------------
// Echoing line editor package
// Shared constants, codes and state types for the line editor core.
// ----------------------------------------------------------------------------
package ele_pkg;

    localparam int LINE_DEPTH = 62;
    localparam int IDX_W      = $clog2(LINE_DEPTH);
    localparam int CNT_W      = 6;
    localparam int BYTE_W     = 8;
    localparam int CHAR_W     = 7;
    localparam int KIND_W     = 2;
    localparam int ECHO_W     = 2;

    localparam logic [CNT_W-1:0] MAX_CHARS_RST = CNT_W'(LINE_DEPTH);

    // result kinds
    localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd2;

    // byte codes
    localparam logic [BYTE_W-1:0] CH_BS    = 8'd8;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
    localparam logic [BYTE_W-1:0] CH_TILDE = 8'd126;
    localparam logic [BYTE_W-1:0] CH_DEL   = 8'd127;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_ENTER,
        OP_ERASE,
        OP_PRINT
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_READ,
        ST_CHAR,
        ST_END
    } state_t;

endpackage

@@ hw/rtl/echoing_line_editor_core.sv @@
// ----------------------------------------------------------------------------
// Echoing line editor core
// Edits a line from received bytes, echoes edits and emits finished lines.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          contents
//  s_*       in         s_tvalid s_tready s_tdata[7:0]   rx_byte
//  m_*       out        m_tvalid m_tready m_tdata[15:0]  out_byte, line_length
//                       m_tuser[1:0] m_tlast             out_kind, last
//  cfg_*     in         cfg_valid cfg_ready cfg_data     max_chars
//
//  One byte is in work at a time: each echo byte of it goes out in turn, and
//  a finished line streams one character per cycle, while m_tready allows,
//  from the line memory after a read in ST_READ, then the end marker. The
//  line memory has no reset; only entries below the count are ever read.
//  A stalled m_tready holds the sequencer in place.
module echoing_line_editor_core
    import ele_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [13:8] line_length
    output logic [1:0]        m_tuser,   // [1:0] out_kind
    output logic              m_tlast,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data   // max_chars
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  max_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               op_reg, op_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic [ECHO_W-1:0] echo_idx_reg, echo_idx_next;
    logic [ECHO_W-1:0] echo_num_reg, echo_num_next;
    logic              finish_reg, finish_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic [BYTE_W-1:0] out_byte_reg, out_byte_next;
    logic [CNT_W-1:0]  out_len_reg, out_len_next;
    logic              out_last_reg, out_last_next;
    logic              out_load;

    logic [CHAR_W-1:0] line_mem [LINE_DEPTH];
    logic [CHAR_W-1:0] rd_data_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;

    logic [CNT_W-1:0]  limit;
    logic              out_free;
    op_t               op_in;
    logic [CNT_W-1:0]  count_in;
    logic [ECHO_W-1:0] num_in;
    logic [BYTE_W-1:0] echo_byte;
    logic              echo_end;
    logic [IDX_W-1:0]  rd_idx_inc;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {2'b00, out_len_reg, out_byte_reg};
    assign m_tuser   = out_kind_reg;
    assign m_tlast   = out_last_reg;

    assign out_free   = !out_valid_reg || m_tready;
    assign rd_idx_inc = rd_idx_reg + 1'b1;
    assign echo_end   = (echo_idx_reg == echo_num_reg - 1'b1);

    // clamp limit to 1..LINE_DEPTH
    always_comb
    begin
        if (max_reg == '0)
            limit = CNT_W'(1);
        else if (max_reg > CNT_W'(LINE_DEPTH))
            limit = CNT_W'(LINE_DEPTH);
        else
            limit = max_reg;
    end

    // classify the incoming byte
    always_comb
    begin
        if (s_tdata == CH_CR || s_tdata == CH_LF)
            op_in = OP_ENTER;
        else if (s_tdata == CH_BS || s_tdata == CH_DEL)
            op_in = OP_ERASE;
        else if (s_tdata inside {[CH_SPACE:CH_TILDE]})
            op_in = OP_PRINT;
        else
            op_in = OP_NONE;
    end

    always_comb
    begin
        count_in = count_reg;
        num_in   = '0;
        case (op_in)
            OP_ENTER:
            begin
                num_in = ECHO_W'(1);
            end
            OP_ERASE:
            begin
                if (count_reg != '0)
                begin
                    count_in = count_reg - 1'b1;
                    num_in   = ECHO_W'(3);
                end
            end
            OP_PRINT:
            begin
                if (count_reg < CNT_W'(LINE_DEPTH))
                    count_in = count_reg + 1'b1;
                num_in = ECHO_W'(1);
            end
            default:
            begin
                num_in = '0;
            end
        endcase
    end

    always_comb
    begin
        case (op_reg)
            OP_ENTER: echo_byte = CH_LF;
            OP_ERASE: echo_byte = (echo_idx_reg == ECHO_W'(1)) ? CH_SPACE : CH_BS;
            OP_PRINT: echo_byte = byte_reg;
            default:  echo_byte = '0;
        endcase
    end

    assign wr_en   = s_tvalid && s_tready && (op_in == OP_PRINT)
                     && (count_reg < CNT_W'(LINE_DEPTH));
    assign wr_addr = count_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[wr_addr] <= s_tdata[CHAR_W-1:0];
        if (rd_en)
            rd_data_reg <= line_mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        byte_next      = byte_reg;
        echo_idx_next  = echo_idx_reg;
        echo_num_next  = echo_num_reg;
        finish_next    = finish_reg;
        rd_idx_next    = rd_idx_reg;
        rd_en          = 1'b0;
        rd_addr        = rd_idx_reg;
        out_load       = 1'b0;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_len_next   = out_len_reg;
        out_last_next  = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next       = op_in;
                    byte_next     = s_tdata;
                    count_next    = count_in;
                    echo_idx_next = '0;
                    echo_num_next = num_in;
                    finish_next   = (op_in == OP_ENTER) || (count_in >= limit);
                    rd_idx_next   = '0;
                    if (num_in != '0)
                        state_next = ST_ECHO;
                    else if ((op_in == OP_ENTER) || (count_in >= limit))
                        state_next = (count_in == '0) ? ST_END : ST_READ;
                end
            end
            ST_ECHO:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_ECHO;
                    out_byte_next = echo_byte;
                    out_len_next  = '0;
                    out_last_next = echo_end && !finish_reg;
                    echo_idx_next = echo_idx_reg + 1'b1;
                    if (echo_end)
                    begin
                        if (!finish_reg)
                            state_next = ST_IDLE;
                        else if (count_reg == '0)
                            state_next = ST_END;
                        else
                            state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_CHAR;
            end
            ST_CHAR:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_CHAR;
                    out_byte_next = {1'b0, rd_data_reg};
                    out_len_next  = '0;
                    out_last_next = 1'b0;
                    // prefetch the next entry while this one goes out
                    if (CNT_W'(rd_idx_inc) < count_reg)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = rd_idx_inc;
                        rd_idx_next = rd_idx_inc;
                    end
                    else
                    begin
                        state_next = ST_END;
                    end
                end
            end
            ST_END:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_END;
                    out_byte_next = '0;
                    out_len_next  = count_reg;
                    out_last_next = 1'b1;
                    count_next    = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            max_reg       <= MAX_CHARS_RST;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_NONE;
            echo_idx_reg  <= '0;
            echo_num_reg  <= '0;
            finish_reg    <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            echo_idx_reg  <= echo_idx_next;
            echo_num_reg  <= echo_num_next;
            finish_reg    <= finish_next;
            rd_idx_reg    <= rd_idx_next;
            if (cfg_valid && cfg_ready)
                max_reg <= cfg_data;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        out_kind_reg <= out_kind_next;
        out_byte_reg <= out_byte_next;
        out_len_reg  <= out_len_next;
        out_last_reg <= out_last_next;
    end

endmodule
